// ===== design/fret_string_chooser_defines.svh =====
// assertion macros for the fret string chooser
// expects clk and rst_n in the scope where a macro is used
`ifndef FRET_STRING_CHOOSER_DEFINES_SVH
`define FRET_STRING_CHOOSER_DEFINES_SVH

// same-cycle implication
`define FSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fret string chooser check failed");

// next-cycle implication
`define FSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fret string chooser check failed");

`endif

// ===== design/fsc_pkg.sv =====
// shared types, codes and tuning tables for the fret string chooser
// no dependencies
`default_nettype none

package fsc_pkg;

  localparam int NUM_STR        = 6;
  localparam int STR_W          = 3;
  localparam int FRET_W         = 5;
  localparam int NOTE_W         = 7;
  localparam int BEAT_WIDTH     = 24;
  localparam int BEAT_TOLERANCE = 12;
  localparam int COST_W         = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;

  localparam logic [COST_W-1:0] STRETCH_PENALTY = COST_W'(500);
  // open bonus is applied as +5 on every other string, keeping cost unsigned
  localparam logic [COST_W-1:0] OPEN_BONUS      = COST_W'(5);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSTRUMENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TUNING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_POS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRETCH = 2'd3;

  // instrument codes
  localparam logic [1:0] INST_ACOUSTIC = 2'd0;
  localparam logic [1:0] INST_ELECTRIC = 2'd1;
  localparam logic [1:0] INST_BASS     = 2'd2;

  // tuning codes
  localparam logic [1:0] TUN_STANDARD  = 2'd0;
  localparam logic [1:0] TUN_DROP_D    = 2'd1;
  localparam logic [1:0] TUN_HALF_DOWN = 2'd2;
  localparam logic [1:0] TUN_OPEN_G    = 2'd3;

  localparam logic [FRET_W-1:0] ACOUSTIC_MAX_FRET = 5'd20;
  localparam logic [FRET_W-1:0] FULL_MAX_FRET     = 5'd24;
  localparam logic [FRET_W-1:0] MAX_STRETCH_RST   = 5'd4;

  typedef logic [NOTE_W-1:0] pitch_t;

  localparam pitch_t GUITAR_STD [0:5] = '{7'd64, 7'd59, 7'd55, 7'd50, 7'd45, 7'd40};
  localparam pitch_t GUITAR_OPEN_G [0:5] = '{7'd62, 7'd59, 7'd55, 7'd50, 7'd43, 7'd38};
  localparam pitch_t BASS_STD [0:3] = '{7'd43, 7'd38, 7'd33, 7'd28};
  localparam pitch_t GUITAR_DROP_LOW = 7'd38;
  localparam pitch_t BASS_DROP_LOW   = 7'd26;

  typedef struct packed {
    logic [NOTE_W-1:0]     midi_note;
    logic [BEAT_WIDTH-1:0] beat_time;
    logic                  first_of_phrase;
  } in_item_t;

  typedef struct packed {
    logic [STR_W-1:0]      string_index;
    logic [FRET_W-1:0]     fret_number;
    logic [BEAT_WIDTH-1:0] beat_out;
  } out_item_t;

  // derived string set for the current instrument and tuning
  typedef struct packed {
    logic [NUM_STR-1:0]       present;
    logic [FRET_W-1:0]        max_fret;
    pitch_t [NUM_STR-1:0]     open_pitch;
  } tune_t;

  // per-note context shared by all string lanes
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [FRET_W-1:0] pref;
    logic [FRET_W-1:0] last_fret;
    logic [STR_W-1:0]  last_string;
    logic [FRET_W-1:0] max_stretch;
    logic              chord_active;
  } ctx_t;

  typedef struct packed {
    logic              ok;
    logic [FRET_W-1:0] fret;
    logic [COST_W-1:0] cost;
  } lane_t;

  function automatic logic [FRET_W-1:0] absdiff5(input logic [FRET_W-1:0] a,
                                                 input logic [FRET_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

`default_nettype wire

// ===== design/fret_string_chooser.sv =====
// fret string chooser top level: config registers, tracking state, selection
// depends on fsc_pkg, fsc_tuning, fsc_lane and fret_string_chooser_defines.svh
`default_nettype none

// Places one MIDI note per input beat on a string and fret of the selected
// instrument. Accepts one note every clock cycle while results are taken; a
// result is presented once its note has passed the input register and one
// evaluation stage, which costs all six strings in parallel and writes the
// result register and the tracking state in the same edge, so the next note
// always sees it. A waiting result holds the input register, and the input
// opens again in the cycle that result is taken. Notes that no free string
// can play produce no output beat. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while no note is in flight (not enforced).

module fret_string_chooser
  import fsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "fret_string_chooser_defines.svh"

  // configuration
  logic [1:0]        instrument_r;
  logic [1:0]        tuning_r;
  logic [FRET_W-1:0] pref_r;
  logic [FRET_W-1:0] max_stretch_r;

  // pipeline
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      advance;

  // tracking state
  logic [STR_W-1:0]      last_string_r, last_string_nxt;
  logic [FRET_W-1:0]     last_fret_r, last_fret_nxt;
  logic [BEAT_WIDTH-1:0] beat_ref_r, beat_ref_nxt;
  logic                  beat_open_r;
  logic [NUM_STR-1:0]    used_r, used_nxt;

  // evaluation
  tune_t                 tune;
  ctx_t                  ctx;
  lane_t                 lane [NUM_STR];
  logic                  restart;
  logic [STR_W-1:0]      ls_eff;
  logic [FRET_W-1:0]     lf_eff;
  logic [NUM_STR-1:0]    used_pre, used_eff;
  logic [BEAT_WIDTH-1:0] beat_diff;
  logic                  new_beat;
  logic                  found;
  logic [STR_W-1:0]      best_idx;
  logic [FRET_W-1:0]     best_fret;
  logic [COST_W-1:0]     best_cost;

  // checker terms
  logic                  placed;
  logic                  out_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      instrument_r  <= INST_ACOUSTIC;
      tuning_r      <= TUN_STANDARD;
      pref_r        <= '0;
      max_stretch_r <= MAX_STRETCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INSTRUMENT:  instrument_r  <= cfg_wdata[1:0];
        CFG_TUNING:      tuning_r      <= cfg_wdata[1:0];
        CFG_PREF_POS:    pref_r        <= cfg_wdata[FRET_W-1:0];
        CFG_MAX_STRETCH: max_stretch_r <= cfg_wdata[FRET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsc_tuning u_tuning (
    .instrument (instrument_r),
    .tuning     (tuning_r),
    .tune       (tune)
  );

  // phrase restart and beat grouping ahead of the string costs
  always_comb begin
    restart   = in_data_r.first_of_phrase;
    ls_eff    = restart ? '0 : last_string_r;
    lf_eff    = restart ? pref_r : last_fret_r;
    used_pre  = restart ? '0 : used_r;
    beat_diff = (in_data_r.beat_time >= beat_ref_r) ? in_data_r.beat_time - beat_ref_r
                                                    : beat_ref_r - in_data_r.beat_time;
    new_beat  = restart || !beat_open_r || (beat_diff > BEAT_WIDTH'(BEAT_TOLERANCE));
    used_eff  = new_beat ? '0 : used_pre;

    ctx.note         = in_data_r.midi_note;
    ctx.pref         = pref_r;
    ctx.last_fret    = lf_eff;
    ctx.last_string  = ls_eff;
    ctx.max_stretch  = max_stretch_r;
    ctx.chord_active = (used_eff != '0);
  end

  for (genvar g = 0; g < NUM_STR; g++) begin : g_lane
    fsc_lane u_lane (
      .ctx        (ctx),
      .open_pitch (tune.open_pitch[g]),
      .present    (tune.present[g]),
      .used       (used_eff[g]),
      .max_fret   (tune.max_fret),
      .str_idx    (STR_W'(g)),
      .res        (lane[g])
    );
  end

  // strict less-than keeps the lowest string index on ties
  always_comb begin
    found     = 1'b0;
    best_idx  = '0;
    best_fret = '0;
    best_cost = '1;
    for (int i = 0; i < NUM_STR; i++) begin
      if (lane[i].ok && (!found || lane[i].cost < best_cost)) begin
        found     = 1'b1;
        best_idx  = STR_W'(i);
        best_fret = lane[i].fret;
        best_cost = lane[i].cost;
      end
    end
  end

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    beat_ref_nxt    = new_beat ? in_data_r.beat_time : beat_ref_r;
    last_string_nxt = found ? best_idx : ls_eff;
    last_fret_nxt   = found ? best_fret : lf_eff;
    used_nxt        = used_eff;
    if (found) begin
      used_nxt[best_idx] = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      out_valid_nxt = found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_string_r <= '0;
      last_fret_r   <= '0;
      beat_ref_r    <= '0;
      beat_open_r   <= 1'b0;
      used_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        last_string_r <= last_string_nxt;
        last_fret_r   <= last_fret_nxt;
        beat_ref_r    <= beat_ref_nxt;
        beat_open_r   <= 1'b1;
        used_r        <= used_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance && found) begin
      out_data_r.string_index <= best_idx;
      out_data_r.fret_number  <= best_fret;
      out_data_r.beat_out     <= in_data_r.beat_time;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign placed       = advance && found;
  assign out_in_range = (out_data_r.fret_number <= FULL_MAX_FRET) &&
                        (out_data_r.string_index < STR_W'(NUM_STR));

  `FSC_ASSERT_IMP(a_out_range, out_valid_r, out_in_range)
  `FSC_ASSERT_NXT(a_used_marked, placed, used_r[$past(best_idx)] && (last_fret_r == $past(best_fret)))
  `FSC_ASSERT_IMP(a_rise_from_item, $rose(out_valid_r), $past(advance) && $past(found))

endmodule

`default_nettype wire

// ===== design/fsc_tuning.sv =====
// open string pitches, string set and fret limit from instrument and tuning
// depends on fsc_pkg
`default_nettype none

module fsc_tuning
  import fsc_pkg::*;
(
  input  wire logic [1:0] instrument,
  input  wire logic [1:0] tuning,
  output tune_t           tune
);

  always_comb begin
    tune = '0;
    case (instrument) inside
      INST_ACOUSTIC, INST_ELECTRIC: begin
        tune.present  = '1;
        tune.max_fret = (instrument == INST_ACOUSTIC) ? ACOUSTIC_MAX_FRET : FULL_MAX_FRET;
        for (int i = 0; i < NUM_STR; i++) begin
          tune.open_pitch[i] = (tuning == TUN_OPEN_G) ? GUITAR_OPEN_G[i] : GUITAR_STD[i];
        end
        if (tuning == TUN_DROP_D) begin
          tune.open_pitch[5] = GUITAR_DROP_LOW;
        end
      end
      INST_BASS: begin
        tune.present  = 6'b001111;
        tune.max_fret = FULL_MAX_FRET;
        for (int i = 0; i < 4; i++) begin
          tune.open_pitch[i] = BASS_STD[i];
        end
        if (tuning == TUN_DROP_D) begin
          tune.open_pitch[3] = BASS_DROP_LOW;
        end
      end
      default: begin
        tune = '0;
      end
    endcase
    // absent strings may wrap here, they are masked by present
    if (tuning == TUN_HALF_DOWN) begin
      for (int i = 0; i < NUM_STR; i++) begin
        tune.open_pitch[i] = tune.open_pitch[i] - 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/fsc_lane.sv =====
// cost of playing the note on one string
// depends on fsc_pkg
`default_nettype none

module fsc_lane
  import fsc_pkg::*;
(
  input  wire ctx_t              ctx,
  input  wire pitch_t            open_pitch,
  input  wire logic              present,
  input  wire logic              used,
  input  wire logic [FRET_W-1:0] max_fret,
  input  wire logic [STR_W-1:0]  str_idx,
  output lane_t                  res
);

  logic [NOTE_W:0]   diff;
  logic [FRET_W-1:0] fret;
  logic [FRET_W-1:0] d_pref;
  logic [FRET_W-1:0] d_last;
  logic [STR_W-1:0]  d_str;
  logic              stretch;
  logic              open_bonus;

  always_comb begin
    diff       = {1'b0, ctx.note} - {1'b0, open_pitch};
    fret       = diff[FRET_W-1:0];
    d_pref     = absdiff5(fret, ctx.pref);
    d_last     = absdiff5(fret, ctx.last_fret);
    d_str      = (str_idx > ctx.last_string) ? str_idx - ctx.last_string
                                             : ctx.last_string - str_idx;
    stretch    = ctx.chord_active && (d_last > ctx.max_stretch) &&
                 (fret != '0) && (ctx.last_fret != '0);
    open_bonus = (fret == '0) && (ctx.pref <= 5'd3);

    res.ok   = present && !used && !diff[NOTE_W] &&
               (diff[NOTE_W-1:0] <= {2'b00, max_fret});
    res.fret = fret;
    res.cost = {4'b0, d_pref, 1'b0} + {5'b0, d_last} + {6'b0, d_str, 1'b0}
             + (stretch ? STRETCH_PENALTY : '0)
             + (open_bonus ? '0 : OPEN_BONUS);
  end

endmodule

`default_nettype wire
